>>> design/fmp_pkg.sv
// Shared definitions for the Fibonacci-modulo-m block: widths, defaults,
// microcode opcodes, jump conditions, sequencer step numbers and the microcode ROM.
// No dependencies.
package fmp_pkg;

	localparam int CFG_W            = 11;
	localparam int IDX_W            = 63;
	localparam int DEF_MAX_MODULUS  = 1024;
	localparam int DEF_PERIOD_DEPTH = 6144;
	localparam logic [CFG_W-1:0] MOD_RESET = 11'd2;

	localparam int OP_W   = 4;
	localparam int COND_W = 3;
	localparam int STEP_W = 4;

	localparam logic [OP_W-1:0] OP_NOP    = 4'd0;
	localparam logic [OP_W-1:0] OP_W0     = 4'd1;
	localparam logic [OP_W-1:0] OP_W1     = 4'd2;
	localparam logic [OP_W-1:0] OP_BSTEP  = 4'd3;
	localparam logic [OP_W-1:0] OP_DINIT  = 4'd4;
	localparam logic [OP_W-1:0] OP_DSTEP  = 4'd5;
	localparam logic [OP_W-1:0] OP_READ   = 4'd6;
	localparam logic [OP_W-1:0] OP_EMIT_T = 4'd7;
	localparam logic [OP_W-1:0] OP_EMIT_Z = 4'd8;

	localparam logic [COND_W-1:0] C_NEVER   = 3'd0;
	localparam logic [COND_W-1:0] C_ALWAYS  = 3'd1;
	localparam logic [COND_W-1:0] C_NOSTART = 3'd2;
	localparam logic [COND_W-1:0] C_MSMALL  = 3'd3;
	localparam logic [COND_W-1:0] C_VALID   = 3'd4;
	localparam logic [COND_W-1:0] C_NBDONE  = 3'd5;
	localparam logic [COND_W-1:0] C_NDLAST  = 3'd6;

	localparam logic [STEP_W-1:0] ST_IDLE  = 4'd0;
	localparam logic [STEP_W-1:0] ST_CHKM  = 4'd1;
	localparam logic [STEP_W-1:0] ST_CHKV  = 4'd2;
	localparam logic [STEP_W-1:0] ST_BW0   = 4'd3;
	localparam logic [STEP_W-1:0] ST_BW1   = 4'd4;
	localparam logic [STEP_W-1:0] ST_BLOOP = 4'd5;
	localparam logic [STEP_W-1:0] ST_DINIT = 4'd6;
	localparam logic [STEP_W-1:0] ST_DSTEP = 4'd7;
	localparam logic [STEP_W-1:0] ST_READ  = 4'd8;
	localparam logic [STEP_W-1:0] ST_OUT   = 4'd9;
	localparam logic [STEP_W-1:0] ST_ZERO  = 4'd10;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [COND_W-1:0] cond;
		logic [STEP_W-1:0] target;
	} uword_t;

	typedef struct packed {
		logic m_small;
		logic tbl_valid;
		logic bdone;
		logic div_last;
	} dp_status_t;

	function automatic uword_t ucode_rom(input logic [STEP_W-1:0] step);
		uword_t w;
		case (step)
			ST_IDLE:  w = '{OP_NOP,    C_NOSTART, ST_IDLE};
			ST_CHKM:  w = '{OP_NOP,    C_MSMALL,  ST_ZERO};
			ST_CHKV:  w = '{OP_NOP,    C_VALID,   ST_DINIT};
			ST_BW0:   w = '{OP_W0,     C_NEVER,   ST_IDLE};
			ST_BW1:   w = '{OP_W1,     C_NEVER,   ST_IDLE};
			ST_BLOOP: w = '{OP_BSTEP,  C_NBDONE,  ST_BLOOP};
			ST_DINIT: w = '{OP_DINIT,  C_NEVER,   ST_IDLE};
			ST_DSTEP: w = '{OP_DSTEP,  C_NDLAST,  ST_DSTEP};
			ST_READ:  w = '{OP_READ,   C_NEVER,   ST_IDLE};
			ST_OUT:   w = '{OP_EMIT_T, C_ALWAYS,  ST_IDLE};
			ST_ZERO:  w = '{OP_EMIT_Z, C_ALWAYS,  ST_IDLE};
			default:  w = '{OP_NOP,    C_ALWAYS,  ST_IDLE};
		endcase
		return w;
	endfunction

endpackage

>>> design/fibonacci_mod_pisano_top.sv
// Top level of the Fibonacci-modulo-m block: microcode sequencer plus datapath.
// Depends on fmp_pkg, fmp_seq and fmp_dp.
//
// A request is taken at a rising edge with start high and busy low; index is
// sampled then. The answer F(index) mod m appears on value, with done high
// for exactly one cycle. The receiver cannot stall, so done is a pure pulse.
// The modulus is written through cfg_valid/cfg_ready/modulus; cfg_ready is
// high whenever busy is low. A write marks the period table stale.
// When the table is current, a request runs two check steps, one divider
// setup step, 63 remainder steps of the bit-serial unit that reduces the
// index by the period, one table read step and one output step.
// The first request after reset or a modulus write first builds the table,
// one entry per cycle, before the divider setup step.
// A modulus below two makes the check step jump to the zero output step.
// A new request may be accepted in the cycle done is high; no request is
// taken while busy is high, that is while one is still being worked on.
// Reset restores modulus 2 and marks the table stale; the table is not cleared.
module fibonacci_mod_pisano_top #(
	parameter int MAX_MODULUS  = fmp_pkg::DEF_MAX_MODULUS,
	parameter int PERIOD_DEPTH = fmp_pkg::DEF_PERIOD_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [fmp_pkg::IDX_W-1:0]      index,
	output logic                           done,
	output logic [$clog2(MAX_MODULUS)-1:0] value,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [fmp_pkg::CFG_W-1:0]      modulus
);
	import fmp_pkg::*;

	logic [OP_W-1:0] op;
	dp_status_t      stat;
	logic            accept;

	assign accept    = start && !busy;
	assign cfg_ready = !busy;

	fmp_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.op     (op),
		.busy   (busy)
	);

	fmp_dp #(
		.MAX_MODULUS  (MAX_MODULUS),
		.PERIOD_DEPTH (PERIOD_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (op),
		.accept   (accept),
		.index    (index),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (modulus),
		.stat     (stat),
		.value    (value),
		.done     (done)
	);

endmodule

>>> design/fmp_seq.sv
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on fmp_pkg.
module fmp_seq (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  fmp_pkg::dp_status_t     stat,
	output logic [fmp_pkg::OP_W-1:0] op,
	output logic                    busy
);
	import fmp_pkg::*;

	logic [STEP_W-1:0] step_q;
	uword_t            uw;
	logic              jump;

	assign uw   = ucode_rom(step_q);
	assign op   = uw.op;
	assign busy = (step_q != ST_IDLE);

	always_comb begin
		case (uw.cond)
			C_NEVER:   jump = 1'b0;
			C_ALWAYS:  jump = 1'b1;
			C_NOSTART: jump = !start;
			C_MSMALL:  jump = stat.m_small;
			C_VALID:   jump = stat.tbl_valid;
			C_NBDONE:  jump = !stat.bdone;
			C_NDLAST:  jump = !stat.div_last;
			default:   jump = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else if (jump) begin
			step_q <= uw.target;
		end else begin
			step_q <= step_q + STEP_W'(1);
		end
	end

`ifndef ASSERT_OFF
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= ST_ZERO)
		else $error("sequencer step outside the program");
	a_start_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == ST_IDLE && start) |=> (step_q == ST_CHKM))
		else $error("accepted request did not start the program");
	a_emit_returns: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == ST_OUT || step_q == ST_ZERO) |=> (step_q == ST_IDLE))
		else $error("result step did not return to idle");
`endif

endmodule

>>> design/fmp_dp.sv
// Datapath: modulus register, Fibonacci recurrence, period table memory,
// bit-serial remainder unit and result register. Depends on fmp_pkg.
module fmp_dp #(
	parameter int MAX_MODULUS  = fmp_pkg::DEF_MAX_MODULUS,
	parameter int PERIOD_DEPTH = fmp_pkg::DEF_PERIOD_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [fmp_pkg::OP_W-1:0]          op,
	input  logic                              accept,
	input  logic [fmp_pkg::IDX_W-1:0]         index,
	input  logic                              cfg_we,
	input  logic [fmp_pkg::CFG_W-1:0]         cfg_data,
	output fmp_pkg::dp_status_t               stat,
	output logic [$clog2(MAX_MODULUS)-1:0]    value,
	output logic                              done
);
	import fmp_pkg::*;

	localparam int MW    = $clog2(MAX_MODULUS + 1);
	localparam int VW    = $clog2(MAX_MODULUS);
	localparam int AW    = $clog2(PERIOD_DEPTH);
	localparam int LW    = $clog2(PERIOD_DEPTH + 1);
	localparam int XW    = (CFG_W > MW) ? CFG_W : MW;
	localparam int CNT_W = $clog2(IDX_W);

	logic [CFG_W-1:0] modulus_q;
	logic             tbl_valid_q;
	logic [LW-1:0]    period_q;
	logic             done_q;
	logic [IDX_W-1:0] idx_q;
	logic [VW-1:0]    prev_q, cur_q;
	logic [LW-1:0]    len_q;
	logic [LW-1:0]    rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic [VW-1:0]    rdata_q;
	logic [VW-1:0]    value_q;
	logic [VW-1:0]    mem [PERIOD_DEPTH];

	logic [MW-1:0]    m_eff;
	logic [VW:0]      sum, m_ext, nxt_w;
	logic [VW-1:0]    nxt;
	logic             pisano, full, bdone;
	logic [LW:0]      shl, per_ext, rem_w;
	logic             we;
	logic [AW-1:0]    waddr;
	logic [VW-1:0]    wdata;

	assign m_eff = (XW'(modulus_q) > XW'(MAX_MODULUS)) ? MW'(MAX_MODULUS) : MW'(modulus_q);

	assign sum    = {1'b0, prev_q} + {1'b0, cur_q};
	assign m_ext  = (VW + 1)'(m_eff);
	assign nxt_w  = (sum >= m_ext) ? (sum - m_ext) : sum;
	assign nxt    = nxt_w[VW-1:0];
	assign pisano = (cur_q == '0) && (nxt == VW'(1));
	assign full   = (len_q >= LW'(PERIOD_DEPTH));
	assign bdone  = pisano || full;

	assign shl     = {rem_q, idx_q[cnt_q]};
	assign per_ext = {1'b0, period_q};
	assign rem_w   = (shl >= per_ext) ? (shl - per_ext) : shl;

	assign stat.m_small   = (m_eff < MW'(2));
	assign stat.tbl_valid = tbl_valid_q;
	assign stat.bdone     = bdone;
	assign stat.div_last  = (cnt_q == '0);

	assign value = value_q;
	assign done  = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q   <= MOD_RESET;
			tbl_valid_q <= 1'b0;
			period_q    <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= (op == OP_EMIT_T) || (op == OP_EMIT_Z);
			if (cfg_we) begin
				modulus_q   <= cfg_data;
				tbl_valid_q <= 1'b0;
			end else if (op == OP_BSTEP && bdone) begin
				tbl_valid_q <= 1'b1;
				period_q    <= pisano ? (len_q - LW'(1)) : LW'(PERIOD_DEPTH);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q <= index;
		end
		case (op)
			OP_W1: begin
				prev_q <= '0;
				cur_q  <= VW'(1);
				len_q  <= LW'(2);
			end
			OP_BSTEP: begin
				if (!bdone) begin
					prev_q <= cur_q;
					cur_q  <= nxt;
					len_q  <= len_q + LW'(1);
				end
			end
			OP_DINIT: begin
				rem_q <= '0;
				cnt_q <= CNT_W'(IDX_W - 1);
			end
			OP_DSTEP: begin
				rem_q <= rem_w[LW-1:0];
				cnt_q <= cnt_q - CNT_W'(1);
			end
			OP_EMIT_T: value_q <= rdata_q;
			OP_EMIT_Z: value_q <= '0;
			default: ;
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = len_q[AW-1:0];
		wdata = nxt;
		case (op)
			OP_W0: begin
				we    = 1'b1;
				waddr = '0;
				wdata = '0;
			end
			OP_W1: begin
				we    = 1'b1;
				waddr = AW'(1);
				wdata = VW'(1);
			end
			OP_BSTEP: we = !bdone;
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (op == OP_READ) begin
			rdata_q <= mem[rem_q[AW-1:0]];
		end
	end

`ifndef ASSERT_OFF
	a_period_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_valid_q |-> (period_q != '0))
		else $error("valid table with zero period");
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_DSTEP) |-> (rem_q < period_q))
		else $error("remainder not below the period");
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(op == OP_EMIT_T || op == OP_EMIT_Z))
		else $error("result strobe without a result step");
	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_EMIT_Z) |=> (done_q && value_q == '0))
		else $error("small modulus did not give zero");
`endif

endmodule

>>> tb/sv/tb_fibonacci_mod_pisano_top.sv
// Testbench for fibonacci_mod_pisano_top: modulus writes and index requests, each answer
// checked against a Pisano-table predictor kept in the bench. Depends on fmp_pkg and the RTL.
module tb_fibonacci_mod_pisano_top;
	timeunit 1ns;
	timeprecision 1ps;

	import fmp_pkg::*;

	localparam int VAL_W        = $clog2(DEF_MAX_MODULUS);
	localparam int TABLE_DEPTH  = DEF_PERIOD_DEPTH;
	localparam int MAX_MOD      = DEF_MAX_MODULUS;
	localparam int DRAIN_CYCLES = 80;
	localparam int RANDOM_ITEMS = 510;
	localparam longint unsigned CYCLE_LIMIT = 64'd3000000;

	typedef struct packed {
		logic [IDX_W-1:0] n;
		logic [VAL_W-1:0] fib;
	} fib_query_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [IDX_W-1:0] index;
	logic             done;
	logic [VAL_W-1:0] value;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CFG_W-1:0] modulus;

	fib_query_t       expected_fib[$];
	logic [VAL_W-1:0] pisano_table[TABLE_DEPTH];
	int unsigned      pisano_len;
	bit               pisano_ok;
	logic [CFG_W-1:0] modulus_shadow;
	int               idle_pct;
	int unsigned      sent_count, checked_count, write_count, build_count, error_count;
	longint unsigned  cycle_count;

	fibonacci_mod_pisano_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.index     (index),
		.done      (done),
		.value     (value),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.modulus   (modulus)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void build_pisano(input int unsigned m);
		int unsigned prev, cur, nxt, len;
		bit closed;
		prev = 0;
		cur = 1 % m;
		len = 2;
		closed = 1'b0;
		pisano_table[0] = '0;
		pisano_table[1] = cur[VAL_W-1:0];
		while (!closed) begin
			nxt = (prev + cur) % m;
			if (cur == 0 && nxt == 1) begin
				pisano_len = len - 1;
				closed = 1'b1;
			end else if (len >= TABLE_DEPTH) begin
				pisano_len = TABLE_DEPTH;
				closed = 1'b1;
			end else begin
				pisano_table[len] = nxt[VAL_W-1:0];
				len++;
				prev = cur;
				cur = nxt;
			end
		end
		pisano_ok = 1'b1;
		build_count++;
	endfunction

	function automatic logic [VAL_W-1:0] predict_fib(input logic [IDX_W-1:0] n);
		int unsigned m;
		logic [IDX_W-1:0] pos;
		m = (modulus_shadow > MAX_MOD) ? MAX_MOD : modulus_shadow;
		if (m < 2)
			return '0;
		if (!pisano_ok)
			build_pisano(m);
		if (pisano_len == 0)
			return '0;
		pos = n % pisano_len;
		if (pos >= TABLE_DEPTH)
			return '0;
		return pisano_table[pos];
	endfunction

	function automatic logic [CFG_W-1:0] pick_modulus();
		case ($urandom_range(10))
			0, 1, 2, 3: return CFG_W'($urandom_range(40, 2));
			4, 5:       return CFG_W'($urandom_range(MAX_MOD, 41));
			6:          return CFG_W'($urandom_range(2047, MAX_MOD + 1));
			7:          return CFG_W'($urandom_range(1, 0));
			8:          return $urandom_range(1) ? CFG_W'(MAX_MOD) : CFG_W'(2047);
			9:          return modulus_shadow;
			default:    return CFG_W'($urandom_range(2047, 0));
		endcase
	endfunction

	function automatic logic [IDX_W-1:0] pick_index();
		logic [63:0] r;
		r = {$urandom, $urandom};
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: return r[IDX_W-1:0];
			6, 7:             return IDX_W'($urandom_range(400, 0));
			8:                return r[IDX_W-1:0] >> $urandom_range(62, 1);
			default:          return {IDX_W{1'b1}} - IDX_W'($urandom_range(50, 0));
		endcase
	endfunction

	task automatic send_query(input logic [IDX_W-1:0] n);
		bit taken;
		fib_query_t req;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			start <= ($urandom_range(99) >= idle_pct);
			index <= n;
			@(posedge clk);
			taken = start && !busy;
		end
		req.n = n;
		req.fib = predict_fib(n);
		expected_fib = {expected_fib, req};
		sent_count++;
	endtask

	task automatic write_modulus(input logic [CFG_W-1:0] m);
		@(negedge clk);
		start <= 1'b0;
		while (expected_fib.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_valid <= 1'b1;
		modulus <= m;
		do @(posedge clk); while (!cfg_ready);
		modulus_shadow = m;
		pisano_ok = 1'b0;
		write_count++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_default_modulus();
		send_query('0);
		send_query(IDX_W'(1));
		send_query(IDX_W'(2));
		send_query(IDX_W'(3));
		send_query({IDX_W{1'b1}});
	endtask

	task automatic test_degenerate_moduli();
		write_modulus(CFG_W'(0));
		send_query('0);
		send_query({IDX_W{1'b1}});
		write_modulus(CFG_W'(1));
		send_query(IDX_W'(1));
		send_query(IDX_W'(12345));
	endtask

	task automatic test_saturated_modulus();
		write_modulus(CFG_W'(2047));
		send_query(IDX_W'(1536));
		send_query(IDX_W'(1537));
		write_modulus(CFG_W'(MAX_MOD + 1));
		send_query(IDX_W'(2));
	endtask

	task automatic test_rewrite_same_modulus();
		write_modulus(CFG_W'(10));
		send_query(IDX_W'(59));
		send_query(IDX_W'(60));
		send_query(IDX_W'(61));
		write_modulus(CFG_W'(10));
		send_query(IDX_W'(1));
		send_query({IDX_W{1'b1}} - IDX_W'(1));
	endtask

	task automatic test_longest_period();
		write_modulus(CFG_W'(250));
		send_query(IDX_W'(1499));
		send_query(IDX_W'(1500));
	endtask

	task automatic test_index_bit_patterns();
		write_modulus(CFG_W'(MAX_MOD));
		send_query(IDX_W'(1) << (IDX_W - 1));
		send_query(IDX_W'({(IDX_W + 1) / 2{2'b01}}));
		send_query(IDX_W'({(IDX_W + 1) / 2{2'b10}}));
		send_query(IDX_W'(MAX_MOD + 511));
	endtask

	task automatic test_random_traffic(input int pct, input int count);
		int left, batch;
		idle_pct = pct;
		left = count;
		while (left > 0) begin
			write_modulus(pick_modulus());
			batch = $urandom_range(60, 15);
			if (batch > left)
				batch = left;
			repeat (batch) send_query(pick_index());
			left -= batch;
		end
	endtask

	always @(posedge clk) begin
		fib_query_t want;
		if (arst_n && done) begin
			if (expected_fib.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual value %0d", $time, value);
				error_count++;
			end else begin
				want = expected_fib.pop_front();
				checked_count++;
				if (value !== want.fib) begin
					$display("%0t: index %0d: expected value %0d, actual %0d",
						$time, want.n, want.fib, value);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d results outstanding",
				$time, cycle_count, expected_fib.size());
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		index = '0;
		cfg_valid = 1'b0;
		modulus = MOD_RESET;
		modulus_shadow = MOD_RESET;
		pisano_ok = 1'b0;
		pisano_len = 0;
		idle_pct = 9;
		sent_count = 0;
		checked_count = 0;
		write_count = 0;
		build_count = 0;
		error_count = 0;
		cycle_count = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_default_modulus();
		test_degenerate_moduli();
		test_saturated_modulus();
		test_rewrite_same_modulus();
		test_longest_period();
		test_index_bit_patterns();
		test_random_traffic(9, RANDOM_ITEMS);
		test_random_traffic(78, RANDOM_ITEMS);
		test_random_traffic(0, RANDOM_ITEMS);

		@(negedge clk);
		start <= 1'b0;
		while (expected_fib.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d requests across %0d modulus writes, %0d period tables rebuilt.",
			sent_count, write_count, build_count);
		$display("Checked %0d answers, %0d mismatches.", checked_count, error_count);
		if (error_count == 0 && expected_fib.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
